// ===== rtl/mbde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbde_pkg
// Shared types and constants for the button debounce and edge detect block.
// ----------------------------------------------------------------------------
package mbde_pkg;

  localparam int unsigned NumButtons  = 16;
  localparam int unsigned IdxW        = $clog2(NumButtons);
  localparam int unsigned NumTimeRegs = 8;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned TimeW       = 16;
  localparam int unsigned NowW        = 32;

  // Button map
  localparam logic [4:0] LastDigital = 5'd9;
  localparam logic [4:0] LastTrigger = 5'd11;
  localparam logic [4:0] HatUp       = 5'd12;
  localparam logic [4:0] HatRight    = 5'd13;
  localparam logic [4:0] HatDown     = 5'd14;

  localparam logic [9:0] TriggerThreshold = 10'd512;

  // Hat sector bounds in degrees, inclusive
  localparam logic signed [9:0] HatZero = 10'sd0;
  localparam logic signed [9:0] Hat45   = 10'sd45;
  localparam logic signed [9:0] Hat135  = 10'sd135;
  localparam logic signed [9:0] Hat225  = 10'sd225;
  localparam logic signed [9:0] Hat315  = 10'sd315;

  // Classified poll, handed from front to back
  typedef struct packed {
    logic              bad;
    logic [IdxW-1:0]   idx;
    logic              raw;
    logic [NowW-1:0]   now;
  } item_t;

  // One result beat
  typedef struct packed {
    logic raw_active;
    logic raw_pressed;
    logic raw_released;
    logic deb_active;
    logic deb_pressed;
    logic deb_released;
    logic bad_index;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/mbde_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbde_front
// Classifies a poll: checks the index and derives the raw button value.
// ----------------------------------------------------------------------------
module mbde_front (
  input  wire logic [4:0]        button_index_i,
  input  wire logic              raw_bit_i,
  input  wire logic [9:0]        trigger_level_i,
  input  wire logic signed [9:0] hat_angle_i,
  input  wire logic [31:0]       now_ms_i,
  output mbde_pkg::item_t        item_o
);

  logic raw;
  logic hat_up, hat_right, hat_down, hat_left;

  assign hat_up    = (hat_angle_i >= mbde_pkg::HatZero && hat_angle_i <= mbde_pkg::Hat45) ||
                     (hat_angle_i >= mbde_pkg::Hat315);
  assign hat_right = (hat_angle_i >= mbde_pkg::Hat45) && (hat_angle_i <= mbde_pkg::Hat135);
  assign hat_down  = (hat_angle_i >= mbde_pkg::Hat135) && (hat_angle_i <= mbde_pkg::Hat225);
  assign hat_left  = (hat_angle_i >= mbde_pkg::Hat225) && (hat_angle_i <= mbde_pkg::Hat315);

  always_comb begin
    if (button_index_i <= mbde_pkg::LastDigital) begin
      raw = raw_bit_i;
    end else if (button_index_i <= mbde_pkg::LastTrigger) begin
      raw = trigger_level_i > mbde_pkg::TriggerThreshold;
    end else if (button_index_i == mbde_pkg::HatUp) begin
      raw = hat_up;
    end else if (button_index_i == mbde_pkg::HatRight) begin
      raw = hat_right;
    end else if (button_index_i == mbde_pkg::HatDown) begin
      raw = hat_down;
    end else begin
      raw = hat_left;
    end
  end

  assign item_o.bad = button_index_i[4];
  assign item_o.idx = button_index_i[mbde_pkg::IdxW-1:0];
  assign item_o.raw = raw;
  assign item_o.now = now_ms_i;

endmodule
`default_nettype wire

// ===== rtl/mbde_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbde_fifo
// Two-entry queue of classified polls between front and back.
// ----------------------------------------------------------------------------
module mbde_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire mbde_pkg::item_t push_item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output mbde_pkg::item_t      pop_item_o
);

  mbde_pkg::item_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign full_o     = count_q[1];
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== rtl/mbde_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbde_back
// Per-button debounce state, time registers and the result register.
// ----------------------------------------------------------------------------
module mbde_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mbde_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mbde_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                           item_valid_i,
  input  wire mbde_pkg::item_t                item_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output mbde_pkg::result_t                   result_o
);

  logic [mbde_pkg::CfgDataW-1:0] times_q [mbde_pkg::NumTimeRegs];
  logic [mbde_pkg::NumButtons-1:0] deb_q, prev_q;
  logic [mbde_pkg::NowW-1:0]       last_q [mbde_pkg::NumButtons];

  logic                          out_valid_q;
  mbde_pkg::result_t             result_q, result_d;

  logic [mbde_pkg::CfgDataW-1:0] treg;
  logic [31:0]                   tpair;
  logic [mbde_pkg::TimeW-1:0]    hold_time;
  logic [mbde_pkg::NowW-1:0]     elapsed;
  logic                          deb_cur, prev_cur, change;

  assign pop_o = item_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    treg      = times_q[item_i.idx[mbde_pkg::IdxW-1:1]];
    tpair     = item_i.idx[0] ? treg[63:32] : treg[31:0];
    // activate time in low half, clear time in high half
    hold_time = item_i.raw ? tpair[15:0] : tpair[31:16];
    deb_cur   = deb_q[item_i.idx];
    prev_cur  = prev_q[item_i.idx];
    elapsed   = item_i.now - last_q[item_i.idx];
    change    = !item_i.bad && (item_i.raw != deb_cur) &&
                (elapsed > {16'd0, hold_time});

    result_d = '0;
    if (item_i.bad) begin
      result_d.bad_index = 1'b1;
    end else begin
      result_d.raw_active   = item_i.raw;
      result_d.raw_pressed  = item_i.raw && !prev_cur;
      result_d.raw_released = !item_i.raw && prev_cur;
      result_d.deb_active   = change ? item_i.raw : deb_cur;
      result_d.deb_pressed  = change && item_i.raw;
      result_d.deb_released = change && !item_i.raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mbde_pkg::NumTimeRegs; i++) begin
        times_q[i] <= '0;
      end
      for (int i = 0; i < mbde_pkg::NumButtons; i++) begin
        last_q[i] <= '0;
      end
      deb_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // writes beyond the last register are dropped
      if (cfg_we_i && !cfg_idx_i[mbde_pkg::CfgIdxW-1]) begin
        times_q[cfg_idx_i[mbde_pkg::CfgIdxW-2:0]] <= cfg_wdata_i;
      end
      if (pop_o && !item_i.bad) begin
        prev_q[item_i.idx] <= item_i.raw;
        if (change) begin
          deb_q[item_i.idx]  <= item_i.raw;
          last_q[item_i.idx] <= item_i.now;
        end
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule
`default_nettype wire

// ===== rtl/multi_button_debounce_edge_detect.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_button_debounce_edge_detect
// Polls one of sixteen buttons per beat, debounces it and reports edges.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------
//  in        in_valid/in_ready    button_index, raw_bit, trigger_level,
//                                 hat_angle, now_ms
//  out       out_valid/out_ready  raw/debounced active, pressed, released,
//                                 bad_index
//  cfg       cfg_we               cfg_idx (4 bits), cfg_wdata (64 bits)
//
// One beat per cycle while out_ready stays high; a result passes the queue slot,
// then the result register, after its poll is accepted, and is held until
// out_ready takes it.
// The per-button state read-modify-write is done in the back end as a poll pops.
// Reset clears all button state and time registers at once; no sweep.
// A two-entry queue absorbs output stalls; in_ready drops when it is full.
// ----------------------------------------------------------------------------
module multi_button_debounce_edge_detect (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [4:0]                    button_index_i,
  input  wire logic                          raw_bit_i,
  input  wire logic [9:0]                    trigger_level_i,
  input  wire logic signed [9:0]             hat_angle_i,
  input  wire logic [31:0]                   now_ms_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               raw_active_o,
  output logic                               raw_pressed_o,
  output logic                               raw_released_o,
  output logic                               debounced_active_o,
  output logic                               debounced_pressed_o,
  output logic                               debounced_released_o,
  output logic                               bad_index_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbde_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [mbde_pkg::CfgDataW-1:0] cfg_wdata_i
);

  mbde_pkg::item_t   front_item, queue_item;
  mbde_pkg::result_t result;
  logic              queue_full, queue_valid, pop;
  logic              push;

  assign in_ready_o = !queue_full;
  assign push       = in_valid_i && !queue_full;

  mbde_front u_front (
    .button_index_i  (button_index_i),
    .raw_bit_i       (raw_bit_i),
    .trigger_level_i (trigger_level_i),
    .hat_angle_i     (hat_angle_i),
    .now_ms_i        (now_ms_i),
    .item_o          (front_item)
  );

  mbde_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .valid_o     (queue_valid),
    .pop_item_o  (queue_item)
  );

  mbde_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (queue_valid),
    .item_i       (queue_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign raw_active_o         = result.raw_active;
  assign raw_pressed_o        = result.raw_pressed;
  assign raw_released_o       = result.raw_released;
  assign debounced_active_o   = result.deb_active;
  assign debounced_pressed_o  = result.deb_pressed;
  assign debounced_released_o = result.deb_released;
  assign bad_index_o          = result.bad_index;

endmodule
`default_nettype wire
